// ----- src/poll_scheduler_with_command_watchdog_top_defines.svh -----
// Assertion macros used by the checker file of the poll scheduler.
// Expects signals named clock and reset in the scope of use.
`ifndef POLL_SCHEDULER_WITH_COMMAND_WATCHDOG_TOP_DEFINES_SVH
`define POLL_SCHEDULER_WITH_COMMAND_WATCHDOG_TOP_DEFINES_SVH

// same-cycle implication
`define PSW_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define PSW_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- src/psw_pkg.sv -----
// Shared types and constants for the poll scheduler with command watchdog.
// No dependencies.
package psw_pkg;

   localparam int INTERVAL_WIDTH = 16;
   localparam int CURRENT_WIDTH  = 18;
   localparam int REQUEST_WIDTH  = 19;
   localparam int CSR_WIDTH      = 18;
   localparam int CSR_IDX_WIDTH  = 3;

   localparam logic [7:0] IMU_REPLY_ID    = 8'd65;
   localparam logic [7:0] VALUES_REPLY_ID = 8'd4;

   localparam logic [1:0] CMD_TICK    = 2'd0;
   localparam logic [1:0] CMD_CONTROL = 2'd1;
   localparam logic [1:0] CMD_REPLY   = 2'd2;

   localparam logic [1:0] WD_NONE  = 2'd0;
   localparam logic [1:0] WD_COAST = 2'd1;
   localparam logic [1:0] WD_BRAKE = 2'd2;

   localparam logic [1:0] POLL_NONE  = 2'd0;
   localparam logic [1:0] POLL_IMU   = 2'd1;
   localparam logic [1:0] POLL_MOTOR = 2'd2;

   localparam logic [CSR_IDX_WIDTH-1:0] REG_IMU_INTERVAL   = 3'd0;
   localparam logic [CSR_IDX_WIDTH-1:0] REG_MOTOR_INTERVAL = 3'd1;
   localparam logic [CSR_IDX_WIDTH-1:0] REG_POLL_TIMEOUT   = 3'd2;
   localparam logic [CSR_IDX_WIDTH-1:0] REG_WD_TIMEOUT     = 3'd3;
   localparam logic [CSR_IDX_WIDTH-1:0] REG_WD_MODE        = 3'd4;
   localparam logic [CSR_IDX_WIDTH-1:0] REG_WD_BRAKE       = 3'd5;
   localparam logic [CSR_IDX_WIDTH-1:0] REG_MAX_BRAKE      = 3'd6;

   localparam logic [INTERVAL_WIDTH-1:0] POLL_TIMEOUT_RESET = 16'd100;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EVAL,
      ST_DIV,
      ST_DONE
   } ctrl_state_type;

   typedef struct packed {
      logic load;
      logic eval;
      logic due_wr;
      logic rsp_load;
   } ctrl_cmd_type;

   typedef struct packed {
      logic poll_go;
      logic div_done;
   } dp_status_type;

   typedef struct packed {
      logic                     accepted;
      logic [CURRENT_WIDTH-1:0] brake_ma;
      logic [1:0]               wd_fired;
      logic [1:0]               poll;
      logic [1:0]               matched;
      logic                     poll_expired;
   } result_type;

endpackage

// ----- src/psw_rdiv.sv -----
// Iterative remainder unit: dividend mod divisor, one quotient bit per cycle.
// Depends on psw_pkg.
module psw_rdiv import psw_pkg::*; #(
   parameter int TIME_BITS = 32
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [TIME_BITS-1:0]      dividend,
   input  logic [INTERVAL_WIDTH-1:0] divisor,
   output logic                      done,
   output logic [INTERVAL_WIDTH-1:0] rem
);

   localparam int CNT_W = $clog2(TIME_BITS + 1);

   logic                      run_ff, run_in;
   logic                      done_ff, done_in;
   logic [CNT_W-1:0]          cnt_ff, cnt_in;
   logic [TIME_BITS-1:0]      num_ff, num_in;
   logic [INTERVAL_WIDTH-1:0] den_ff, den_in;
   logic [INTERVAL_WIDTH-1:0] rem_ff, rem_in;
   logic [INTERVAL_WIDTH:0]   trial;
   logic [INTERVAL_WIDTH:0]   diff;
   logic                      last;

   assign trial = {rem_ff, num_ff[TIME_BITS-1]};
   assign diff  = trial - {1'b0, den_ff};
   assign last  = (cnt_ff == CNT_W'(1));

   always_comb begin
      run_in  = run_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      num_in  = num_ff;
      den_in  = den_ff;
      rem_in  = rem_ff;
      if (start) begin
         run_in = 1'b1;
         cnt_in = CNT_W'(TIME_BITS);
         num_in = dividend;
         den_in = divisor;
         rem_in = '0;
      end else if (run_ff) begin
         num_in = {num_ff[TIME_BITS-2:0], 1'b0};
         rem_in = (trial >= {1'b0, den_ff}) ? diff[INTERVAL_WIDTH-1:0]
                                           : trial[INTERVAL_WIDTH-1:0];
         cnt_in = cnt_ff - CNT_W'(1);
         if (last) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      num_ff <= num_in;
      den_ff <= den_in;
      rem_ff <= rem_in;
   end

   assign done = done_ff;
   assign rem  = rem_ff;

endmodule

// ----- src/psw_dp.sv -----
// Datapath: settings, timers, poll and watchdog state, result registers.
// Depends on psw_pkg and psw_rdiv.
module psw_dp import psw_pkg::*; #(
   parameter int TIME_BITS = 32
) (
   input  logic                     clock,
   input  logic                     reset,
   input  ctrl_cmd_type             cmd,
   output dp_status_type            status,
   input  logic [1:0]               req_command,
   input  logic [7:0]               req_reply_id,
   input  logic                     req_is_brake,
   input  logic [REQUEST_WIDTH-1:0] req_brake_request_ma,
   input  logic                     csr_write_en,
   input  logic [CSR_IDX_WIDTH-1:0] csr_index,
   input  logic [CSR_WIDTH-1:0]     csr_wdata,
   output result_type               rsp
);

   typedef logic [TIME_BITS-1:0] tm_type;

   function automatic logic reached(input tm_type a, input tm_type b);
      tm_type d;
      d = b - a;
      return !d[TIME_BITS-1];
   endfunction

   function automatic logic [CURRENT_WIDTH-1:0] min_ma(input logic [CURRENT_WIDTH-1:0] a,
                                                     input logic [CURRENT_WIDTH-1:0] b);
      return (a < b) ? a : b;
   endfunction

   // settings
   logic [INTERVAL_WIDTH-1:0] imu_int_ff, imu_int_in;
   logic [INTERVAL_WIDTH-1:0] mot_int_ff, mot_int_in;
   logic [INTERVAL_WIDTH-1:0] tmo_ff, tmo_in;
   logic [INTERVAL_WIDTH-1:0] wd_tmo_ff, wd_tmo_in;
   logic [1:0]                wd_mode_ff, wd_mode_in;
   logic [CURRENT_WIDTH-1:0]  wd_brake_ff, wd_brake_in;
   logic [CURRENT_WIDTH-1:0]  max_brake_ff, max_brake_in;

   // latched event
   logic [1:0]               ev_cmd_ff;
   logic [7:0]               ev_rid_ff;
   logic                     ev_brake_ff;
   logic [REQUEST_WIDTH-1:0] ev_req_ff;

   // scheduler state
   tm_type time_ff, time_in;
   tm_type imu_due_ff, imu_due_in;
   tm_type mot_due_ff, mot_due_in;
   tm_type reply_dl_ff, reply_dl_in;
   tm_type guard_dl_ff, guard_dl_in;
   logic   busy_ff, busy_in;
   logic   kind_ff, kind_in;
   logic   armed_ff, armed_in;

   result_type res_ff, res_in;
   result_type rsp_ff;

   tm_type                    time_next;
   tm_type                    due_new;
   logic                      expire, guard_en, fire;
   logic                      imu_ok, mot_ok, imu_win, take_mot, poll_go;
   logic [CURRENT_WIDTH-1:0]  amt;
   logic                      accept;
   logic [7:0]                want_id;
   logic                      div_done;
   logic [INTERVAL_WIDTH-1:0] div_rem;
   tm_type                    div_num;
   logic [INTERVAL_WIDTH-1:0] div_den;

   always_comb begin
      imu_int_in   = imu_int_ff;
      mot_int_in   = mot_int_ff;
      tmo_in       = tmo_ff;
      wd_tmo_in    = wd_tmo_ff;
      wd_mode_in   = wd_mode_ff;
      wd_brake_in  = wd_brake_ff;
      max_brake_in = max_brake_ff;
      if (csr_write_en) begin
         case (csr_index)
            REG_IMU_INTERVAL:   imu_int_in   = csr_wdata[INTERVAL_WIDTH-1:0];
            REG_MOTOR_INTERVAL: mot_int_in   = csr_wdata[INTERVAL_WIDTH-1:0];
            REG_POLL_TIMEOUT:   tmo_in       = csr_wdata[INTERVAL_WIDTH-1:0];
            REG_WD_TIMEOUT:     wd_tmo_in    = csr_wdata[INTERVAL_WIDTH-1:0];
            REG_WD_MODE:        wd_mode_in   = csr_wdata[1:0];
            REG_WD_BRAKE:       wd_brake_in  = csr_wdata[CURRENT_WIDTH-1:0];
            REG_MAX_BRAKE:      max_brake_in = csr_wdata[CURRENT_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   assign time_next = time_ff + tm_type'(1);
   assign expire    = busy_ff && reached(reply_dl_ff, time_next);
   assign guard_en  = (wd_tmo_ff != '0) &&
                      ((wd_mode_ff == WD_COAST) ||
                       ((wd_mode_ff == WD_BRAKE) && (wd_brake_ff != '0) &&
                        (max_brake_ff != '0)));
   assign fire      = guard_en && armed_ff && reached(guard_dl_ff, time_next);
   assign imu_ok    = (imu_int_ff != '0) && reached(imu_due_ff, time_next);
   assign mot_ok    = (mot_int_ff != '0) && reached(mot_due_ff, time_next);
   assign imu_win   = imu_ok && !(mot_ok && (mot_due_ff != imu_due_ff) &&
                                  reached(mot_due_ff, imu_due_ff));
   assign take_mot  = !imu_win && mot_ok;
   assign poll_go   = (!busy_ff || expire) && (imu_win || mot_ok);

   assign amt = (!ev_req_ff[REQUEST_WIDTH-1] && (ev_req_ff[CURRENT_WIDTH-1:0] != '0) &&
                 (max_brake_ff != '0)) ? min_ma(ev_req_ff[CURRENT_WIDTH-1:0], max_brake_ff)
                                       : '0;
   assign accept  = !ev_brake_ff || (amt != '0);
   assign want_id = kind_ff ? VALUES_REPLY_ID : IMU_REPLY_ID;

   assign div_num = time_next - (take_mot ? mot_due_ff : imu_due_ff);
   assign div_den = take_mot ? mot_int_ff : imu_int_ff;
   // next deadline: now minus lateness mod interval, plus one interval
   assign due_new = time_ff - tm_type'(div_rem) +
                    tm_type'(kind_ff ? mot_int_ff : imu_int_ff);

   assign status.poll_go  = (ev_cmd_ff == CMD_TICK) && poll_go;
   assign status.div_done = div_done;

   always_comb begin
      time_in     = time_ff;
      imu_due_in  = imu_due_ff;
      mot_due_in  = mot_due_ff;
      reply_dl_in = reply_dl_ff;
      guard_dl_in = guard_dl_ff;
      busy_in     = busy_ff;
      kind_in     = kind_ff;
      armed_in    = armed_ff;
      res_in      = res_ff;
      if (cmd.eval) begin
         res_in = '0;
         case (ev_cmd_ff)
            CMD_TICK: begin
               time_in = time_next;
               if (expire) begin
                  busy_in             = 1'b0;
                  res_in.poll_expired = 1'b1;
               end
               if (fire) begin
                  armed_in        = 1'b0;
                  guard_dl_in     = '0;
                  res_in.wd_fired = wd_mode_ff;
                  if (wd_mode_ff == WD_BRAKE) begin
                     res_in.brake_ma = min_ma(wd_brake_ff, max_brake_ff);
                  end
               end
               if (poll_go) begin
                  busy_in     = 1'b1;
                  kind_in     = take_mot;
                  reply_dl_in = time_next + tm_type'(tmo_ff);
                  res_in.poll = take_mot ? POLL_MOTOR : POLL_IMU;
               end
            end
            CMD_CONTROL: begin
               if (ev_brake_ff) begin
                  res_in.brake_ma = amt;
               end
               if (accept) begin
                  res_in.accepted = 1'b1;
                  if (guard_en) begin
                     guard_dl_in = time_ff + tm_type'(wd_tmo_ff);
                     armed_in    = 1'b1;
                  end
               end
            end
            CMD_REPLY: begin
               if (busy_ff && (ev_rid_ff == want_id)) begin
                  busy_in        = 1'b0;
                  res_in.matched = kind_ff ? POLL_MOTOR : POLL_IMU;
               end
            end
            default: ;
         endcase
      end
      if (cmd.due_wr) begin
         if (kind_ff) begin
            mot_due_in = due_new;
         end else begin
            imu_due_in = due_new;
         end
      end
   end

   psw_rdiv #(.TIME_BITS(TIME_BITS)) u_rdiv (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.eval && status.poll_go),
      .dividend (div_num),
      .divisor  (div_den),
      .done     (div_done),
      .rem      (div_rem)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         imu_int_ff   <= '0;
         mot_int_ff   <= '0;
         tmo_ff       <= POLL_TIMEOUT_RESET;
         wd_tmo_ff    <= '0;
         wd_mode_ff   <= WD_NONE;
         wd_brake_ff  <= '0;
         max_brake_ff <= '0;
         time_ff      <= '0;
         imu_due_ff   <= '0;
         mot_due_ff   <= '0;
         reply_dl_ff  <= '0;
         guard_dl_ff  <= '0;
         busy_ff      <= 1'b0;
         kind_ff      <= 1'b0;
         armed_ff     <= 1'b0;
      end else begin
         imu_int_ff   <= imu_int_in;
         mot_int_ff   <= mot_int_in;
         tmo_ff       <= tmo_in;
         wd_tmo_ff    <= wd_tmo_in;
         wd_mode_ff   <= wd_mode_in;
         wd_brake_ff  <= wd_brake_in;
         max_brake_ff <= max_brake_in;
         time_ff      <= time_in;
         imu_due_ff   <= imu_due_in;
         mot_due_ff   <= mot_due_in;
         reply_dl_ff  <= reply_dl_in;
         guard_dl_ff  <= guard_dl_in;
         busy_ff      <= busy_in;
         kind_ff      <= kind_in;
         armed_ff     <= armed_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         ev_cmd_ff   <= req_command;
         ev_rid_ff   <= req_reply_id;
         ev_brake_ff <= req_is_brake;
         ev_req_ff   <= req_brake_request_ma;
      end
      res_ff <= res_in;
      if (cmd.rsp_load) begin
         rsp_ff <= res_ff;
      end
   end

   assign rsp = rsp_ff;

endmodule

// ----- src/psw_ctrl.sv -----
// Controller: sequences event intake, evaluation, deadline update, result transfer.
// Depends on psw_pkg.
module psw_ctrl import psw_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   output ctrl_cmd_type  cmd,
   input  dp_status_type status
);

   ctrl_state_type state_ff, state_in;
   logic           rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_EVAL;
            end
         end
         ST_EVAL: begin
            cmd.eval = 1'b1;
            state_in = status.poll_go ? ST_DIV : ST_DONE;
         end
         ST_DIV: begin
            if (status.div_done) begin
               cmd.due_wr = 1'b1;
               state_in   = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.rsp_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// ----- src/poll_scheduler_with_command_watchdog_top.sv -----
// Poll scheduler with command watchdog. Events (tick, control command, reply)
// arrive one per transfer and each gives one result transfer. An event is
// taken in the idle state and evaluated, then its result is loaded into the
// output register in the done state and the block returns to idle. A tick
// that issues a poll passes a divide state between evaluation and the done
// state, as the next poll deadline needs the lateness modulo the interval,
// worked out one bit per cycle by the remainder unit.
// A result waits in an output register, so the next event is taken meanwhile.
// The user must write settings via the csr port only while idle; not enforced.
module poll_scheduler_with_command_watchdog_top import psw_pkg::*; #(
   parameter int TIME_BITS = 32
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [1:0]                      req_command,
   input  logic [7:0]                      req_reply_id,
   input  logic                            req_is_brake,
   input  logic signed [REQUEST_WIDTH-1:0] req_brake_request_ma,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic                            rsp_command_accepted,
   output logic [CURRENT_WIDTH-1:0]        rsp_brake_out_ma,
   output logic [1:0]                      rsp_watchdog_fired,
   output logic [1:0]                      rsp_poll_issued,
   output logic [1:0]                      rsp_reply_matched,
   output logic                            rsp_poll_timed_out,
   input  logic                            csr_write_en,
   input  logic [CSR_IDX_WIDTH-1:0]        csr_index,
   input  logic [CSR_WIDTH-1:0]            csr_wdata
);

   ctrl_cmd_type  cmd;
   dp_status_type status;
   result_type    rsp;

   psw_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .status    (status)
   );

   psw_dp #(.TIME_BITS(TIME_BITS)) u_dp (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .status               (status),
      .req_command          (req_command),
      .req_reply_id         (req_reply_id),
      .req_is_brake         (req_is_brake),
      .req_brake_request_ma (req_brake_request_ma),
      .csr_write_en         (csr_write_en),
      .csr_index            (csr_index),
      .csr_wdata            (csr_wdata),
      .rsp                  (rsp)
   );

   assign rsp_command_accepted = rsp.accepted;
   assign rsp_brake_out_ma     = rsp.brake_ma;
   assign rsp_watchdog_fired   = rsp.wd_fired;
   assign rsp_poll_issued      = rsp.poll;
   assign rsp_reply_matched    = rsp.matched;
   assign rsp_poll_timed_out   = rsp.poll_expired;

endmodule

// ----- src/psw_chk.sv -----
// Port-level checks for the poll scheduler top level, bound to it below.
// Depends on psw_pkg and poll_scheduler_with_command_watchdog_top_defines.svh.
`include "poll_scheduler_with_command_watchdog_top_defines.svh"

module psw_chk import psw_pkg::*; (
   input logic                     clock,
   input logic                     reset,
   input logic                     rsp_valid,
   input logic                     rsp_ready,
   input logic                     rsp_command_accepted,
   input logic [CURRENT_WIDTH-1:0] rsp_brake_out_ma,
   input logic [1:0]               rsp_watchdog_fired,
   input logic [1:0]               rsp_poll_issued,
   input logic [1:0]               rsp_reply_matched,
   input logic                     rsp_poll_timed_out
);

   `PSW_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_brake_out_ma) && $stable(rsp_poll_issued) && $stable(rsp_reply_matched), "result changed while stalled")

   `PSW_ASSERT_NOW(a_poll_is_tick, rsp_valid && (rsp_poll_issued != POLL_NONE), (rsp_reply_matched == POLL_NONE) && !rsp_command_accepted, "poll mixed with non-tick result")

   `PSW_ASSERT_NOW(a_timeout_is_tick, rsp_valid && rsp_poll_timed_out, (rsp_reply_matched == POLL_NONE) && !rsp_command_accepted, "timeout mixed with non-tick result")

   `PSW_ASSERT_NOW(a_coast_zero, rsp_valid && (rsp_watchdog_fired == WD_COAST), rsp_brake_out_ma == '0, "coast with nonzero current")

endmodule

bind poll_scheduler_with_command_watchdog_top psw_chk u_psw_chk (.*);
